>>> hw/rtl/bwu_pkg.sv
// Package for the barycentric weight unit: default parameters and shared widths.
// Depends on nothing; used by the interfaces, the divider and the top level.
package bwu_pkg;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned LANES          = 3;
  localparam int unsigned LANE_A         = 0;
  localparam int unsigned LANE_B         = 1;
  localparam int unsigned LANE_C         = 2;
endpackage

>>> hw/rtl/bwu_if.sv
// Stream interfaces of the barycentric weight unit: sample beats in, weight beats out.
// Depends on bwu_pkg for default widths.
interface bwu_in_if import bwu_pkg::*; #(
  parameter int unsigned CW = COORD_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] pixel_x;
  logic [CW-1:0] pixel_y;
  logic [CW-1:0] vert_a_x;
  logic [CW-1:0] vert_a_y;
  logic [CW-1:0] vert_b_x;
  logic [CW-1:0] vert_b_y;
  logic [CW-1:0] vert_c_x;
  logic [CW-1:0] vert_c_y;
  modport source (output valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                  vert_c_x, vert_c_y, input ready);
  modport sink (input valid, pixel_x, pixel_y, vert_a_x, vert_a_y, vert_b_x, vert_b_y,
                vert_c_x, vert_c_y, output ready);
endinterface

interface bwu_out_if import bwu_pkg::*; #(
  parameter int unsigned WW = FRAC_BITS_DEF + 1
);
  logic          valid;
  logic          ready;
  logic [WW-1:0] weight_a;
  logic [WW-1:0] weight_b;
  logic [WW-1:0] weight_c;
  logic          degenerate;
  modport source (output valid, weight_a, weight_b, weight_c, degenerate, input ready);
  modport sink (input valid, weight_a, weight_b, weight_c, degenerate, output ready);
endinterface

>>> hw/rtl/bwu_div.sv
// Pipelined restoring divider, LANES lanes, one quotient bit per stage, F+1 stages.
// Per lane: clamp(floor(num * 2^F / den), 0, 2^F), or 0 if ovr; depends on bwu_pkg.
module bwu_div import bwu_pkg::*; #(
  parameter int unsigned W  = 37,
  parameter int unsigned F  = FRAC_BITS_DEF,
  parameter int unsigned TW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [TW-1:0] in_tag,
  input  logic [W-1:0]  num [LANES],
  input  logic [W-1:0]  den [LANES],
  input  logic          ovr [LANES],
  output logic          out_valid,
  output logic [TW-1:0] out_tag,
  output logic [F:0]    quo [LANES]
);
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

  logic          v    [0:F];
  logic [TW-1:0] tag  [0:F];
  logic [W-1:0]  rem  [0:F][LANES];
  logic [W-1:0]  dv   [0:F][LANES];
  logic [F:0]    q    [0:F][LANES];
  logic          done [0:F][LANES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag[0] <= in_tag;
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= num[l];
        dv[0][l]  <= den[l];
        if (ovr[l]) begin
          done[0][l] <= 1'b1;
          q[0][l]    <= '0;
        end else if (num[l] >= den[l]) begin
          done[0][l] <= 1'b1;
          q[0][l]    <= ONE;
        end else begin
          done[0][l] <= 1'b0;
          q[0][l]    <= '0;
        end
      end
    end
  end

  for (genvar k = 1; k <= F; k++) begin : g_stage
    logic [W:0] r2 [LANES];
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        r2[l] = {rem[k-1][l], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag[k] <= tag[k-1];
        for (int l = 0; l < LANES; l++) begin
          dv[k][l]   <= dv[k-1][l];
          done[k][l] <= done[k-1][l];
          if (done[k-1][l]) begin
            rem[k][l] <= rem[k-1][l];
            q[k][l]   <= q[k-1][l];
          end else if (r2[l] >= {1'b0, dv[k-1][l]}) begin
            rem[k][l] <= W'(r2[l] - {1'b0, dv[k-1][l]});
            q[k][l]   <= {q[k-1][l][F-1:0], 1'b1};
          end else begin
            rem[k][l] <= r2[l][W-1:0];
            q[k][l]   <= {q[k-1][l][F-1:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = v[F];
  assign out_tag   = tag[F];
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo[l] = q[F][l];
    end
  end
endmodule

>>> hw/rtl/barycentric_weight_unit_top.sv
// Top level of the barycentric weight unit: edge products, clamped weights, renormalization.
// Depends on bwu_pkg, bwu_if and bwu_div.
//
//   channel  | dir | beat contents
//   sample   | in  | pixel_x/y, vert_a_x/y, vert_b_x/y, vert_c_x/y
//   weights  | out | weight_a, weight_b, weight_c, degenerate
//
// One beat per cycle sustained while weights is not stalled; the pipeline holds two
// bit-per-stage divider pipelines (clamped quotients, then the renormalizing quotients).
// Synchronous reset clears only the valid bits; no clearing pass.
// A stalled weights beat freezes the whole pipeline; sample ready drops in the same cycle.
module barycentric_weight_unit_top import bwu_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  bwu_in_if.sink     sample,
  bwu_out_if.source  weights
);
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned PW = 2 * DW;
  localparam int unsigned UW = PW + 1;
  localparam int unsigned SW = UW + 1;
  localparam int unsigned NW = FRAC_BITS + 3;
  localparam logic [FRAC_BITS:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic en;
  assign en = !weights.valid || weights.ready;
  assign sample.ready = en;

  logic v1, v2, v3, v4, v5;
  logic signed [DW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  logic signed [PW-1:0] p_yz, p_zy, p_zx, p_xz, p_xy, p_yx;
  logic signed [UW-1:0] ux, uy, uz;
  logic [SW-1:0] num1 [LANES];
  logic [SW-1:0] den1 [LANES];
  logic          ovr1 [LANES];
  logic          degen4, degen5;
  logic [FRAC_BITS:0] ra, rb, rc;
  logic               div1_valid;
  logic [0:0]         div1_tag;
  logic [FRAC_BITS:0] q1 [LANES];

  function automatic logic signed [DW-1:0] sx(input logic [COORD_BITS-1:0] x);
    return DW'($signed(x));
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= div1_valid;
    end
  end

  logic signed [SW-1:0] s_full, ux_w, uy_w, uz_w;
  always_comb begin
    ux_w   = SW'(ux);
    uy_w   = SW'(uy);
    uz_w   = SW'(uz);
    s_full = ux_w + uy_w;
  end

  function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] x);
    return x[SW-1] ? SW'(-x) : SW'(x);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      e1x <= sx(sample.vert_c_x[COORD_BITS-1:0]) - sx(sample.vert_a_x[COORD_BITS-1:0]);
      e1y <= sx(sample.vert_b_x[COORD_BITS-1:0]) - sx(sample.vert_a_x[COORD_BITS-1:0]);
      e1z <= sx(sample.vert_a_x[COORD_BITS-1:0]) - sx(sample.pixel_x[COORD_BITS-1:0]);
      e2x <= sx(sample.vert_c_y[COORD_BITS-1:0]) - sx(sample.vert_a_y[COORD_BITS-1:0]);
      e2y <= sx(sample.vert_b_y[COORD_BITS-1:0]) - sx(sample.vert_a_y[COORD_BITS-1:0]);
      e2z <= sx(sample.vert_a_y[COORD_BITS-1:0]) - sx(sample.pixel_y[COORD_BITS-1:0]);
      p_yz <= PW'(e1y) * PW'(e2z);
      p_zy <= PW'(e1z) * PW'(e2y);
      p_zx <= PW'(e1z) * PW'(e2x);
      p_xz <= PW'(e1x) * PW'(e2z);
      p_xy <= PW'(e1x) * PW'(e2y);
      p_yx <= PW'(e1y) * PW'(e2x);
      ux <= UW'(p_yz) - UW'(p_zy);
      uy <= UW'(p_zx) - UW'(p_xz);
      uz <= UW'(p_xy) - UW'(p_yx);
      degen4 <= (uz == '0);
      num1[LANE_A] <= mag(s_full);
      num1[LANE_B] <= mag(uy_w);
      num1[LANE_C] <= mag(ux_w);
      den1[LANE_A] <= mag(uz_w);
      den1[LANE_B] <= mag(uz_w);
      den1[LANE_C] <= mag(uz_w);
      ovr1[LANE_A] <= (s_full == '0) || (s_full[SW-1] != uz_w[SW-1]);
      ovr1[LANE_B] <= (uy_w == '0) || (uy_w[SW-1] != uz_w[SW-1]);
      ovr1[LANE_C] <= (ux_w == '0) || (ux_w[SW-1] != uz_w[SW-1]);
    end
  end

  bwu_div #(.W(SW), .F(FRAC_BITS), .TW(1)) u_div_clamp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v4), .in_tag(degen4),
    .num(num1), .den(den1), .ovr(ovr1),
    .out_valid(div1_valid), .out_tag(div1_tag), .quo(q1)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ra     <= ONE - q1[LANE_A];
      rb     <= q1[LANE_B];
      rc     <= q1[LANE_C];
      degen5 <= div1_tag[0];
    end
  end

  logic [NW-1:0] wsum;
  logic [NW-1:0] num2 [LANES];
  logic [NW-1:0] den2 [LANES];
  logic          ovr2 [LANES];
  always_comb begin
    wsum = NW'(ra) + NW'(rb) + NW'(rc);
    num2[LANE_A] = NW'(ra);
    num2[LANE_B] = NW'(rb);
    num2[LANE_C] = NW'(rc);
    for (int l = 0; l < LANES; l++) begin
      den2[l] = wsum;
      ovr2[l] = (wsum == '0);
    end
  end

  logic [0:0]         div2_tag;
  logic [FRAC_BITS:0] q2 [LANES];

  bwu_div #(.W(NW), .F(FRAC_BITS), .TW(1)) u_div_norm (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v5), .in_tag(degen5),
    .num(num2), .den(den2), .ovr(ovr2),
    .out_valid(weights.valid), .out_tag(div2_tag), .quo(q2)
  );

  assign weights.degenerate = div2_tag[0];
  assign weights.weight_a   = div2_tag[0] ? '0 : q2[LANE_A];
  assign weights.weight_b   = div2_tag[0] ? '0 : q2[LANE_B];
  assign weights.weight_c   = div2_tag[0] ? '0 : q2[LANE_C];
endmodule

>>> hw/rtl/bwu_checker.sv
// Port-level checker for the barycentric weight unit, bound to the top level.
// Depends on bwu_pkg; sees only the top-level ports.
module bwu_checker import bwu_pkg::*; #(
  parameter int unsigned WW = FRAC_BITS_DEF + 1
) (
  input logic          clk,
  input logic          rst,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [WW-1:0] weight_a,
  input logic [WW-1:0] weight_b,
  input logic [WW-1:0] weight_c,
  input logic          degenerate
);
  localparam logic [WW-1:0] ONE = {1'b1, {(WW-1){1'b0}}};

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> weight_a == '0 && weight_b == '0 && weight_c == '0)
    else $error("degenerate beat with nonzero weights");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> weight_a <= ONE && weight_b <= ONE && weight_c <= ONE)
    else $error("weight above one");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("sample ready does not follow output stall");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(weight_a) && $stable(weight_b)
      && $stable(weight_c) && $stable(degenerate))
    else $error("stalled beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");
endmodule

bind barycentric_weight_unit_top bwu_checker #(.WW(FRAC_BITS + 1)) u_bwu_checker (
  .clk(clk), .rst(rst), .in_ready(sample.ready),
  .out_valid(weights.valid), .out_ready(weights.ready),
  .weight_a(weights.weight_a), .weight_b(weights.weight_b),
  .weight_c(weights.weight_c), .degenerate(weights.degenerate)
);
